[rtl/color_bar_gradient_grid_pattern_assert.svh]
// assertion macros used by the pattern generator top level
`ifndef COLOR_BAR_GRADIENT_GRID_PATTERN_ASSERT_SVH
`define COLOR_BAR_GRADIENT_GRID_PATTERN_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CBGG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CBGG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cbgg_pkg.sv]
// types and constants of the color bar gradient grid pattern generator
`timescale 1ns / 1ps
package cbgg_pkg;

	localparam int COORD_BITS   = 12;
	localparam int CFG_BITS     = 13;
	localparam int CFG_IDX_BITS = 1;
	localparam int CHAN_BITS    = 8;
	localparam int GRAD_STAGES  = 8;
	// col * 255 fits in twenty bits
	localparam int NUM_BITS     = COORD_BITS + 8;
	localparam int Y6_BITS      = COORD_BITS + 3;
	localparam int TH_BITS      = CFG_BITS + 3;
	localparam int BAND_COUNT   = 6;
	localparam int BAND_BITS    = $clog2(BAND_COUNT);

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd512;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd384;

	// channel enables per band, red in bit 2, blue in bit 0
	localparam logic [2:0] BAND_RGB [BAND_COUNT] = '{
		3'b111, 3'b110, 3'b101, 3'b010, 3'b101, 3'b100
	};

	typedef struct packed {
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
	} cbgg_in_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
		logic                 outside;
	} cbgg_out_t;

	typedef struct packed {
		logic       outside;
		logic [2:0] rgb;
	} cbgg_side_t;

	typedef struct packed {
		logic                 valid;
		logic [CHAN_BITS-1:0] grad;
		logic                 on_grid;
		cbgg_side_t           side;
	} cbgg_div_res_t;

endpackage

[rtl/cbgg_grad_div.sv]
// pipelined gradient divider with grid remainder reduction
`timescale 1ns / 1ps
module cbgg_grad_div
	import cbgg_pkg::*;
#(
	parameter int GRID_PERIOD     = 64,
	parameter int GRID_LINE_WIDTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [NUM_BITS-1:0]   num,
	input  logic [COORD_BITS-1:0] x,
	input  logic [COORD_BITS-1:0] y,
	input  cbgg_side_t            side,
	input  logic [CFG_BITS-1:0]   divisor,
	output cbgg_div_res_t         res
);

	// grid remainder by restoring reduction against the period shifted left
	localparam int MOD_STEPS     = COORD_BITS - $clog2(GRID_PERIOD) + 1;
	localparam int MOD_PER_STAGE = (MOD_STEPS + GRAD_STAGES - 1) / GRAD_STAGES;

	typedef struct packed {
		logic [NUM_BITS-1:0]   rem;
		logic [CHAN_BITS-1:0]  quo;
		logic [COORD_BITS-1:0] rx;
		logic [COORD_BITS-1:0] ry;
		cbgg_side_t            side;
	} div_pl_t;

	function automatic logic [COORD_BITS-1:0] mod_step(input logic [COORD_BITS-1:0] r,
			input int sh);
		logic [31:0] d;
		d = 32'(GRID_PERIOD) << sh;
		if (32'(r) >= d)
			return r - COORD_BITS'(d);
		return r;
	endfunction

	div_pl_t pl_in [GRAD_STAGES];
	div_pl_t pl_nx [GRAD_STAGES];
	div_pl_t pl_s  [GRAD_STAGES];
	logic    vld_in [GRAD_STAGES];
	logic    vld_s  [GRAD_STAGES];

	assign pl_in[0].rem  = num;
	assign pl_in[0].quo  = '0;
	assign pl_in[0].rx   = x;
	assign pl_in[0].ry   = y;
	assign pl_in[0].side = side;
	assign vld_in[0]     = in_valid;

	genvar s;
	generate
		for (s = 0; s < GRAD_STAGES; s++) begin : g_stage
			localparam int QBIT = GRAD_STAGES - 1 - s;

			logic [NUM_BITS:0] dsub;

			if (s > 0) begin : g_link
				assign pl_in[s]  = pl_s[s-1];
				assign vld_in[s] = vld_s[s-1];
			end

			assign dsub = (NUM_BITS + 1)'(divisor) << QBIT;

			always_comb begin
				pl_nx[s] = pl_in[s];
				if ({1'b0, pl_in[s].rem} >= dsub) begin
					pl_nx[s].rem       = pl_in[s].rem - NUM_BITS'(dsub);
					pl_nx[s].quo[QBIT] = 1'b1;
				end
				for (int j = 0; j < MOD_PER_STAGE; j++) begin
					if (s * MOD_PER_STAGE + j < MOD_STEPS) begin
						pl_nx[s].rx = mod_step(pl_nx[s].rx,
							MOD_STEPS - 1 - (s * MOD_PER_STAGE + j));
						pl_nx[s].ry = mod_step(pl_nx[s].ry,
							MOD_STEPS - 1 - (s * MOD_PER_STAGE + j));
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[s] <= 1'b0;
				else
					vld_s[s] <= vld_in[s];
			end

			always_ff @(posedge clk) begin
				pl_s[s] <= pl_nx[s];
			end
		end
	endgenerate

	assign res.valid   = vld_s[GRAD_STAGES-1];
	assign res.grad    = pl_s[GRAD_STAGES-1].quo;
	assign res.on_grid = (int'(pl_s[GRAD_STAGES-1].rx) < GRID_LINE_WIDTH) ||
		(int'(pl_s[GRAD_STAGES-1].ry) < GRID_LINE_WIDTH);
	assign res.side    = pl_s[GRAD_STAGES-1].side;

endmodule

[rtl/color_bar_gradient_grid_pattern.sv]
// top level of the color bar gradient grid pattern generator
//
//   channel   signals                      transfer when
//   ------    -------                      -------------
//   command   start, busy, coord           start high and busy low at clk rise
//   result    done, pixel                  done high, one cycle, no back-pressure
//   config    cfg_we, cfg_idx, cfg_data    cfg_we high at clk rise
//
// one coordinate per cycle; each command passes through the stages below, in order, to its result
// two input stages (coordinate prep, band compare), eight divider stages that
// each resolve one gradient bit, one output stage
// busy stays low: nothing in the pipeline can stall
// reset clears valid bits and loads width 512, height 384
`timescale 1ns / 1ps
`include "color_bar_gradient_grid_pattern_assert.svh"
module color_bar_gradient_grid_pattern
	import cbgg_pkg::*;
#(
	parameter int GRID_PERIOD     = 64,
	parameter int GRID_LINE_WIDTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  cbgg_in_t                coord,
	output logic                    done,
	output cbgg_out_t               pixel,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	localparam int LATENCY = GRAD_STAGES + 3;

	function automatic logic [CHAN_BITS-1:0] chan_value(input logic en,
			input logic [CHAN_BITS-1:0] grad, input logic grid, input logic outside);
		logic [CHAN_BITS-1:0] c;
		// base channel is 0 or 255, so c*(255-g)/255 is 255-g
		c = en ? ~grad : '0;
		if (grid)
			c = c >> 1;
		if (outside)
			c = '0;
		return c;
	endfunction

	logic [CFG_BITS-1:0]   image_width_q;
	logic [CFG_BITS-1:0]   image_height_q;
	logic                  accept;

	logic                  v_s1;
	logic [NUM_BITS-1:0]   num_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic [Y6_BITS-1:0]    y6_s1;
	logic                  out_s1;
	logic [COORD_BITS:0]   row_p1;

	logic                  v_s2;
	logic [NUM_BITS-1:0]   num_s2;
	logic [COORD_BITS-1:0] x_s2;
	logic [COORD_BITS-1:0] y_s2;
	cbgg_side_t            side_s2;
	logic [BAND_BITS-1:0]  band;

	cbgg_div_res_t         dv;
	logic                  done_q;
	cbgg_out_t             pixel_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: x*255, 6*(y+1) and the bounds check
	assign row_p1 = (COORD_BITS + 1)'(coord.row) + (COORD_BITS + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		num_s1 <= (NUM_BITS'(coord.col) << 8) - NUM_BITS'(coord.col);
		x_s1   <= coord.col;
		y_s1   <= coord.row;
		y6_s1  <= Y6_BITS'({row_p1, 2'b00}) + Y6_BITS'({row_p1, 1'b0});
		out_s1 <= ({1'b0, coord.col} >= image_width_q) ||
			({1'b0, coord.row} >= image_height_q);
	end

	// stage 2: y < floor(k*h/6) is the same as 6*(y+1) <= k*h
	always_comb begin
		band = BAND_BITS'(BAND_COUNT - 1);
		for (int k = BAND_COUNT - 1; k >= 1; k--) begin
			if (TH_BITS'(y6_s1) <= TH_BITS'(image_height_q) * TH_BITS'(k))
				band = BAND_BITS'(k - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		num_s2          <= num_s1;
		x_s2            <= x_s1;
		y_s2            <= y_s1;
		side_s2.outside <= out_s1;
		side_s2.rgb     <= BAND_RGB[band];
	end

	cbgg_grad_div #(
		.GRID_PERIOD     (GRID_PERIOD),
		.GRID_LINE_WIDTH (GRID_LINE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.num      (num_s2),
		.x        (x_s2),
		.y        (y_s2),
		.side     (side_s2),
		.divisor  (image_width_q),
		.res      (dv)
	);

	// output stage: shade, grid dimming, outside blanking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= dv.valid;
	end

	always_ff @(posedge clk) begin
		pixel_q.red     <= chan_value(dv.side.rgb[2], dv.grad, dv.on_grid, dv.side.outside);
		pixel_q.green   <= chan_value(dv.side.rgb[1], dv.grad, dv.on_grid, dv.side.outside);
		pixel_q.blue    <= chan_value(dv.side.rgb[0], dv.grad, dv.on_grid, dv.side.outside);
		pixel_q.outside <= dv.side.outside;
	end

	assign done  = done_q;
	assign pixel = pixel_q;

	`CBGG_ASSERT_NOW(a_done_from_cmd, done, ($past(start && !busy, LATENCY)), "result without command")
	`CBGG_ASSERT_NOW(a_outside_black, (done && pixel.outside), ((pixel.red == '0) && (pixel.green == '0) && (pixel.blue == '0)), "outside pixel not black")
	`CBGG_ASSERT_NOW(a_chan_shared, done, (((pixel.red == '0) || (pixel.green == '0) || (pixel.red == pixel.green)) && ((pixel.red == '0) || (pixel.blue == '0) || (pixel.red == pixel.blue)) && ((pixel.green == '0) || (pixel.blue == '0) || (pixel.green == pixel.blue))), "lit channels differ")
	`CBGG_ASSERT_NEXT(a_bound_flag, (start && !busy && ({1'b0, coord.col} >= image_width_q)), out_s1, "column beyond width not flagged")

endmodule
